### rtl/core/lirs_pkg.sv
// shared constants, types and codes for the linear interpolation resampler
package lirs_pkg;

    localparam int FRAC_BITS_DEF   = 24;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PHASE_INT_BITS  = 3;
    localparam int MAX_RESULTS     = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [0:0] CFG_PHASE_STEP = 1'd0;
    localparam logic [0:0] CFG_MONO       = 1'd1;

    typedef enum logic [1:0] {
        PRIME_EMPTY,
        PRIME_HALF,
        PRIME_FULL
    } prime_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/core/linear_interp_resampler_top.sv
// top level of the stereo linear interpolation resampler
// path: an accepted item waits in the queue, which keeps taking items until full; the back
//   end pops one when idle, then per output frame due multiplies (BK_CALC) and adds into
//   the output register (BK_EMIT), waiting there for the receiver; with none due it goes idle
// reset: synchronous active low; clears pair, phase and priming state, phase_step
//   returns to 1.0 and mono_source to 0; no clearing pass
module linear_interp_resampler_top #(
    parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF,
    parameter int PHASE_W     = FRAC_BITS + lirs_pkg::PHASE_INT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [PHASE_W-1:0]            cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_right_sample,
    input  logic                          s_source_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_left,
    output logic signed [SAMPLE_BITS-1:0] m_out_right,
    output logic                          m_last_of_run
);
    import lirs_pkg::*;

    localparam int JOB_W = 4 * SAMPLE_BITS + 1;
    localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(1) << FRAC_BITS;

    logic [PHASE_W-1:0] phase_step_reg;
    logic               mono_reg;
    queue_status_t      q_status;
    logic               q_push, q_pop;
    logic [JOB_W-1:0]   q_in_job, q_out_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= STEP_RESET;
            mono_reg       <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                CFG_MONO:       mono_reg       <= cfg_wdata[0];
                default:        mono_reg       <= mono_reg;
            endcase
        end
    end

    lirs_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .JOB_W       (JOB_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mono_source    (mono_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_source_done  (s_source_done),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_job          (q_in_job)
    );

    lirs_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in_job),
        .pop       (q_pop),
        .pop_data  (q_out_job),
        .status    (q_status)
    );

    lirs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .PHASE_W     (PHASE_W),
        .JOB_W       (JOB_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .phase_step    (phase_step_reg),
        .q_status      (q_status),
        .q_job         (q_out_job),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_left    (m_out_left),
        .m_out_right   (m_out_right),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### rtl/core/lirs_front.sv
// front end: source item intake, priming, frame pair shift and end detection
module lirs_front #(
    parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
    parameter int JOB_W       = 4 * SAMPLE_BITS + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          mono_source,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_right_sample,
    input  logic                          s_source_done,
    input  lirs_pkg::queue_status_t       q_status,
    output logic                          q_push,
    output logic [JOB_W-1:0]              q_job
);
    import lirs_pkg::*;

    prime_state_t prime_reg, prime_next;
    logic         ended_reg, ended_next;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg, prev_r_reg, cur_l_reg, cur_r_reg;
    logic signed [SAMPLE_BITS-1:0] l_in, r_in;
    logic accept;
    logic end_now;

    always_comb begin
        l_in = s_source_done ? '0 : s_left_sample;
        r_in = s_source_done ? '0 : (mono_source ? s_left_sample : s_right_sample);
    end

    assign accept = s_valid && s_ready;
    // current pair becomes the previous one; all zero plus end marker stops the stream
    assign end_now = s_source_done && (cur_l_reg == '0) && (cur_r_reg == '0);

    // next state
    always_comb begin
        prime_next = prime_reg;
        ended_next = ended_reg;
        if (accept && !ended_reg) begin
            case (prime_reg)
                PRIME_EMPTY: begin
                    prime_next = PRIME_HALF;
                    ended_next = s_source_done;
                end
                PRIME_HALF: begin
                    prime_next = PRIME_FULL;
                end
                PRIME_FULL: begin
                    ended_next = end_now;
                end
                default: begin
                    prime_next = PRIME_EMPTY;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        s_ready = ended_reg || (prime_reg == PRIME_EMPTY) || !q_status.full;
        q_push  = 1'b0;
        q_job   = {1'b0, prev_l_reg, prev_r_reg, l_in, r_in};
        if (accept && !ended_reg) begin
            case (prime_reg)
                PRIME_HALF: begin
                    q_push = 1'b1;
                    q_job  = {1'b0, prev_l_reg, prev_r_reg, l_in, r_in};
                end
                PRIME_FULL: begin
                    q_push = !end_now;
                    q_job  = {1'b1, cur_l_reg, cur_r_reg, l_in, r_in};
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg <= PRIME_EMPTY;
            ended_reg <= 1'b0;
        end else begin
            prime_reg <= prime_next;
            ended_reg <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            cur_l_reg  <= '0;
            cur_r_reg  <= '0;
        end else if (accept && !ended_reg) begin
            case (prime_reg)
                PRIME_EMPTY: begin
                    prev_l_reg <= l_in;
                    prev_r_reg <= r_in;
                end
                PRIME_HALF: begin
                    cur_l_reg <= l_in;
                    cur_r_reg <= r_in;
                end
                default: begin
                    prev_l_reg <= cur_l_reg;
                    prev_r_reg <= cur_r_reg;
                    cur_l_reg  <= l_in;
                    cur_r_reg  <= r_in;
                end
            endcase
        end
    end

endmodule

### rtl/core/lirs_queue.sv
// short job queue between the front end and the interpolation engine
module lirs_queue #(
    parameter int WIDTH = 4 * lirs_pkg::SAMPLE_BITS_DEF + 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        pop_data,
    output lirs_pkg::queue_status_t status
);
    import lirs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic do_push, do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/lirs_back.sv
// back end: phase accumulator and interpolation of output frames
module lirs_back #(
    parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF,
    parameter int PHASE_W     = FRAC_BITS + lirs_pkg::PHASE_INT_BITS,
    parameter int JOB_W       = 4 * SAMPLE_BITS + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [PHASE_W-1:0]            phase_step,
    input  lirs_pkg::queue_status_t       q_status,
    input  logic [JOB_W-1:0]              q_job,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_left,
    output logic signed [SAMPLE_BITS-1:0] m_out_right,
    output logic                          m_last_of_run
);
    import lirs_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int CNT_W  = $clog2(MAX_RESULTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;

    back_state_t state_reg, state_next;

    logic [PHASE_W-1:0] phase_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg, prev_r_reg, cur_l_reg, cur_r_reg;
    logic signed [PROD_W-1:0]      prod_l_reg, prod_r_reg;
    logic                          m_valid_reg, m_last_reg;
    logic signed [SAMPLE_BITS-1:0] m_left_reg, m_right_reg;

    logic                          job_sub;
    logic signed [SAMPLE_BITS-1:0] job_pl, job_pr, job_cl, job_cr;
    logic [PHASE_W-1:0]            phase_in;
    logic                          below_one;
    logic                          out_free;
    logic                          calc_en, emit_en;
    logic [PHASE_W:0]              phase_sum;
    logic [PHASE_W-1:0]            phase_adv;
    logic                          last_now;
    logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PROD_W-1:0]      sum_l, sum_r;

    assign {job_sub, job_pl, job_pr, job_cl, job_cr} = q_job;

    // a new frame lowers the phase by one, saturating at zero
    always_comb begin
        phase_in = phase_reg;
        if (job_sub) begin
            phase_in = (phase_reg >= PHASE_ONE) ? phase_reg - PHASE_ONE : '0;
        end
    end

    assign below_one = (phase_reg[PHASE_W-1:FRAC_BITS] == '0);
    assign out_free  = !m_valid_reg || m_ready;

    assign phase_sum = {1'b0, phase_reg} + {1'b0, phase_step};
    assign phase_adv = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
    assign last_now  = (phase_adv[PHASE_W-1:FRAC_BITS] != '0) || (cnt_reg == CNT_LAST);

    assign diff_l = (SAMPLE_BITS+1)'(cur_l_reg) - (SAMPLE_BITS+1)'(prev_l_reg);
    assign diff_r = (SAMPLE_BITS+1)'(cur_r_reg) - (SAMPLE_BITS+1)'(prev_r_reg);
    assign frac_s = {1'b0, phase_reg[FRAC_BITS-1:0]};

    // arithmetic shift of the product gives the floor
    assign sum_l = PROD_W'(prev_l_reg) + (prod_l_reg >>> FRAC_BITS);
    assign sum_r = PROD_W'(prev_r_reg) + (prod_r_reg >>> FRAC_BITS);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC: begin
                state_next = below_one ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT: begin
                if (out_free) begin
                    state_next = last_now ? BK_IDLE : BK_CALC;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        q_pop   = 1'b0;
        calc_en = 1'b0;
        emit_en = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop   = !q_status.empty;
            BK_CALC: calc_en = below_one;
            BK_EMIT: emit_en = out_free;
            default: q_pop   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                phase_reg <= phase_in;
                cnt_reg   <= '0;
            end else if (emit_en) begin
                phase_reg <= phase_adv;
                cnt_reg   <= cnt_reg + 1'b1;
            end
            if (emit_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            prev_l_reg <= job_pl;
            prev_r_reg <= job_pr;
            cur_l_reg  <= job_cl;
            cur_r_reg  <= job_cr;
        end
        if (calc_en) begin
            prod_l_reg <= diff_l * frac_s;
            prod_r_reg <= diff_r * frac_s;
        end
        if (emit_en) begin
            m_left_reg  <= sum_l[SAMPLE_BITS-1:0];
            m_right_reg <= sum_r[SAMPLE_BITS-1:0];
            m_last_reg  <= last_now;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_left    = m_left_reg;
    assign m_out_right   = m_right_reg;
    assign m_last_of_run = m_last_reg;

endmodule

### rtl/core/lirs_checker.sv
// port level checks for the resampler, bound to the top level
module lirs_checker #(
    parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_out_left,
    input logic signed [SAMPLE_BITS-1:0] m_out_right,
    input logic                          m_last_of_run
);
    import lirs_pkg::*;

    localparam int RUN_W = $clog2(MAX_RESULTS);
    localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_RESULTS - 1);

    logic [1:0]       seen_reg, seen_next;
    logic [RUN_W-1:0] run_reg, run_next;

    // items seen so far, saturating once the pair is primed, and output frames in the current run
    always_comb begin
        seen_next = seen_reg;
        if (s_valid && s_ready && seen_reg != 2'd2) begin
            seen_next = seen_reg + 1'b1;
        end
        run_next = run_reg;
        if (m_valid && m_ready) begin
            run_next = m_last_of_run ? '0 : run_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            run_reg  <= '0;
        end else begin
            seen_reg <= seen_next;
            run_reg  <= run_next;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_left) && $stable(m_out_right)
            && $stable(m_last_of_run))
        else $error("stalled result changed");

    a_primed_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> seen_reg == 2'd2)
        else $error("result before two items primed the pair");

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && run_reg == RUN_LAST |-> m_last_of_run)
        else $error("too many results for one item");

endmodule

bind linear_interp_resampler_top lirs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lirs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_left    (m_out_left),
    .m_out_right   (m_out_right),
    .m_last_of_run (m_last_of_run)
);

### tb/sv/lirs_resample_checker.sv
// checker for the linear interpolation resampler: predicts output frames and compares them
module lirs_resample_checker (
    input  logic                                                    aclk,
    input  logic                                                    aresetn,
    input  logic                                                    cfg_write,
    input  logic [0:0]                                              cfg_index,
    input  logic [lirs_pkg::FRAC_BITS_DEF+lirs_pkg::PHASE_INT_BITS-1:0] cfg_wdata,
    input  logic                                                    s_valid,
    input  logic                                                    s_ready,
    input  logic signed [lirs_pkg::SAMPLE_BITS_DEF-1:0]             s_left_sample,
    input  logic signed [lirs_pkg::SAMPLE_BITS_DEF-1:0]             s_right_sample,
    input  logic                                                    s_source_done,
    input  logic                                                    m_valid,
    input  logic                                                    m_ready,
    input  logic signed [lirs_pkg::SAMPLE_BITS_DEF-1:0]             m_out_left,
    input  logic signed [lirs_pkg::SAMPLE_BITS_DEF-1:0]             m_out_right,
    input  logic                                                    m_last_of_run,
    input  logic                                                    drain_check,
    output int                                                      pending,
    output int                                                      fails
);
    timeunit 1ns;
    timeprecision 1ps;

    import lirs_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int FW = FRAC_BITS_DEF;
    localparam int PW = FRAC_BITS_DEF + PHASE_INT_BITS;
    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FW;
    localparam logic [PW-1:0] PHASE_TOP = '1;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 last;
    } out_frame_t;

    out_frame_t due_frames[$];

    logic [PW-1:0]        phase_step;
    logic                 mono_source;
    logic signed [SW-1:0] prev_left, prev_right, cur_left, cur_right;
    logic [PW-1:0]        phase_acc;
    prime_state_t         prime;
    logic                 stream_ended;

    task automatic flag_mismatch(input string what);
        $display("%0t ns resampler mismatch: %s", $time, what);
        fails++;
    endtask

    // prev + floor((cur - prev) * phase / 2^FW), the arithmetic shift gives the floor
    function automatic logic signed [SW-1:0] interp_sample(input logic signed [SW-1:0] a,
                                                           input logic signed [SW-1:0] b,
                                                           input logic [PW-1:0] ph);
        longint span;
        longint prod;
        span = longint'(b) - longint'(a);
        prod = span * longint'(ph);
        return SW'(longint'(a) + (prod >>> FW));
    endfunction

    function automatic void ingest_frame(input logic signed [SW-1:0] in_left,
                                         input logic signed [SW-1:0] in_right,
                                         input logic done);
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        out_frame_t           frame;
        longint               next_phase;
        int                   n;
        if (stream_ended)
            return;
        l = '0;
        r = '0;
        if (!done) begin
            l = in_left;
            r = mono_source ? in_left : in_right;
        end
        if (prime == PRIME_EMPTY) begin
            prev_left  = l;
            prev_right = r;
            prime      = PRIME_HALF;
            if (done)
                stream_ended = 1'b1;
            return;
        end
        if (prime == PRIME_HALF) begin
            cur_left  = l;
            cur_right = r;
            prime     = PRIME_FULL;
        end else begin
            phase_acc  = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : '0;
            prev_left  = cur_left;
            prev_right = cur_right;
            cur_left   = l;
            cur_right  = r;
            // end marker after an all-zero frame closes the stream
            if (done && prev_left == 0 && prev_right == 0) begin
                stream_ended = 1'b1;
                return;
            end
        end
        n = 0;
        while (phase_acc < PHASE_ONE && n < MAX_RESULTS) begin
            frame.left  = interp_sample(prev_left, cur_left, phase_acc);
            frame.right = interp_sample(prev_right, cur_right, phase_acc);
            next_phase  = longint'(phase_acc) + longint'(phase_step);
            phase_acc   = (next_phase > longint'(PHASE_TOP)) ? PHASE_TOP : PW'(next_phase);
            n++;
            frame.last  = !(phase_acc < PHASE_ONE && n < MAX_RESULTS);
            due_frames.insert(due_frames.size(), frame);
        end
    endfunction

    always @(posedge aclk) begin
        out_frame_t want;
        if (!aresetn) begin
            phase_step   = PHASE_ONE;
            mono_source  = 1'b0;
            prev_left    = '0;
            prev_right   = '0;
            cur_left     = '0;
            cur_right    = '0;
            phase_acc    = '0;
            prime        = PRIME_EMPTY;
            stream_ended = 1'b0;
            due_frames.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_PHASE_STEP: phase_step = cfg_wdata;
                    CFG_MONO: mono_source = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_frames.size() == 0) begin
                    flag_mismatch("output frame with nothing expected");
                end else begin
                    want = due_frames.pop_front();
                    if (m_out_left !== want.left)
                        flag_mismatch($sformatf("out_left %0d, expected %0d",
                                                m_out_left, want.left));
                    if (m_out_right !== want.right)
                        flag_mismatch($sformatf("out_right %0d, expected %0d",
                                                m_out_right, want.right));
                    if (m_last_of_run !== want.last)
                        flag_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                m_last_of_run, want.last));
                end
            end
            if (s_valid && s_ready)
                ingest_frame(s_left_sample, s_right_sample, s_source_done);
            if (drain_check && due_frames.size() != 0) begin
                flag_mismatch($sformatf("%0d output frames never arrived", due_frames.size()));
                due_frames.delete();
            end
        end
        pending <= due_frames.size();
    end

endmodule

### tb/sv/tb_linear_interp_resampler_top.sv
// testbench top for the linear interpolation resampler: stimulus, flow control and verdict
module tb_linear_interp_resampler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lirs_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int FW = FRAC_BITS_DEF;
    localparam int PW = FRAC_BITS_DEF + PHASE_INT_BITS;

    localparam logic [PW-1:0] STEP_UNITY = PW'(1) << FW;
    localparam logic [PW-1:0] STEP_LOW   = PW'(2796203);
    localparam logic [PW-1:0] STEP_HIGH  = PW'(67108864);
    localparam logic [PW-1:0] STEP_TOP   = '1;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam int RANDOM_ITEMS = 160;
    localparam int SETTLE       = 30;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_CYCLES = 300000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_TIGHT
    } rx_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [0:0]           cfg_index = '0;
    logic [PW-1:0]        cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [SW-1:0] s_left_sample = '0;
    logic signed [SW-1:0] s_right_sample = '0;
    logic                 s_source_done = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [SW-1:0] m_out_left;
    logic signed [SW-1:0] m_out_right;
    logic                 m_last_of_run;
    logic                 drain_check = 1'b0;
    int                   pending;
    int                   fails;

    // stimulus bookkeeping
    logic                 long_hold_req = 1'b0;
    logic                 mono_now = 1'b0;
    logic                 last_zero = 1'b0;
    int                   items_sent = 0;
    int                   burst_left = 0;
    int                   cycle_count = 0;

    linear_interp_resampler_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_source_done  (s_source_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_left     (m_out_left),
        .m_out_right    (m_out_right),
        .m_last_of_run  (m_last_of_run)
    );

    lirs_resample_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_source_done  (s_source_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_left     (m_out_left),
        .m_out_right    (m_out_right),
        .m_last_of_run  (m_last_of_run),
        .drain_check    (drain_check),
        .pending        (pending),
        .fails          (fails)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("linear_interp_resampler_top regression: fail");
        $finish;
    end

    // receiver: changing stall patterns, plus one long hold-off once asked for
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        logic     hold_done;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: m_ready <= 1'b1;
                    RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return SW'(-1);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [PW-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return STEP_UNITY;
            1: return STEP_LOW;
            2: return STEP_HIGH;
            3: return STEP_TOP;
            // below the usual range: more outputs due than one item may give
            4: return PW'($urandom_range(0, 32'(STEP_LOW) - 1));
            default: return PW'($urandom_range(32'(STEP_LOW), 32'(STEP_HIGH)));
        endcase
    endfunction

    // offers one item, in bursts with random gaps, and waits until it is taken
    task automatic offer(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                         input logic done);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_left_sample  <= l;
        s_right_sample <= r;
        s_source_done  <= done;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_zero = done || (l == 0 && (mono_now || r == 0));
        items_sent++;
    endtask

    // random item that never closes the stream before the end of the run
    task automatic offer_random();
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        logic                 done;
        l    = pick_sample();
        r    = pick_sample();
        done = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 19) == 0) begin
            l = '0;
            r = '0;
        end
        if (done && (items_sent == 0 || (items_sent >= 2 && last_zero)))
            done = 1'b0;
        offer(l, r, done);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        // items that give no output may still be in flight
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [PW-1:0] value);
        @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_write <= 1'b0;
        if (idx == CFG_MONO)
            mono_now = value[0];
    endtask

    task automatic set_mode(input logic [PW-1:0] step, input logic mono);
        settle();
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_MONO, PW'(mono));
    endtask

    initial begin
        int random_sent;
        int phase_items;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: unity step, stereo; extremes and an end marker mid-stream
        offer(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        offer(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        offer(SW'(-1), SW'(1), 1'b0);
        offer('0, '0, 1'b1);
        offer(SW'(1), SW'(-1), 1'b0);

        // zero step in mono: every item is capped at the most outputs
        set_mode('0, 1'b1);
        offer(SAMPLE_MAX, SW'(5), 1'b0);
        offer(SAMPLE_MIN, SW'(-7), 1'b0);
        offer(SW'(12345), SAMPLE_MIN, 1'b0);

        // largest step: the phase runs into its ceiling
        set_mode(STEP_TOP, 1'b0);
        repeat (10) offer(pick_sample(), pick_sample(), 1'b0);

        set_mode(STEP_LOW, 1'b1);
        offer(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        offer(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        offer('0, SW'(77), 1'b0);

        set_mode(STEP_HIGH, 1'b0);
        offer(SW'(1234), SW'(-4321), 1'b0);
        offer('0, '0, 1'b1);
        offer(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        offer(SAMPLE_MIN, SAMPLE_MAX, 1'b0);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_mode(pick_step(), 1'($urandom_range(0, 1)));
            long_hold_req = 1'b1;
            phase_items = $urandom_range(15, 35);
            repeat (phase_items) offer_random();
            random_sent += phase_items;
        end

        // close the stream with a zero frame then an end marker; later items are ignored
        set_mode(STEP_LOW, 1'b0);
        offer(SAMPLE_MAX, SW'(-3), 1'b0);
        offer('0, '0, 1'b0);
        offer('0, '0, 1'b1);
        repeat (3) offer(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));

        settle();
        @(negedge aclk);
        drain_check <= 1'b1;
        @(negedge aclk);
        drain_check <= 1'b0;
        @(negedge aclk);
        if (fails == 0)
            $display("linear_interp_resampler_top regression: pass");
        else
            $display("linear_interp_resampler_top regression: fail");
        $finish;
    end

endmodule

### files.f
rtl/core/lirs_pkg.sv
rtl/core/lirs_front.sv
rtl/core/lirs_queue.sv
rtl/core/lirs_back.sv
rtl/core/linear_interp_resampler_top.sv
rtl/core/lirs_checker.sv
tb/sv/lirs_resample_checker.sv
tb/sv/tb_linear_interp_resampler_top.sv
